[hw/rtl/tgl_pkg.sv]
// ----------------------------------------------------------------------------
// tgl_pkg
// Types and constants shared by the text glyph layout block.
// ----------------------------------------------------------------------------
package tgl_pkg;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_LARGE_FONT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TEXT_COLOR = 1'd1;

	localparam logic        LARGE_FONT_RESET = 1'b1;
	localparam logic [23:0] TEXT_COLOR_RESET = 24'hC0C0C0;

	localparam logic OP_START = 1'b0;
	localparam logic OP_TEXT  = 1'b1;

	localparam logic [7:0] HZ_BASE = 8'd161;
	localparam logic [6:0] HZ_ROW  = 7'd94;
	localparam logic [9:0] ROW_MAX = 10'd1023;

	typedef enum logic [1:0] {
		KIND_ASCII_SMALL = 2'd0,
		KIND_ASCII_LARGE = 2'd1,
		KIND_HANZI_SMALL = 2'd2,
		KIND_HANZI_LARGE = 2'd3
	} glyph_kind_t;

	typedef struct packed {
		logic       op;
		logic [8:0] start_x;
		logic [9:0] start_y;
		logic [7:0] code_byte;
	} text_word_t;

	typedef struct packed {
		glyph_kind_t glyph_kind;
		logic [20:0] glyph_offset;
		logic [8:0]  pos_x;
		logic [9:0]  pos_y;
		logic [23:0] draw_color;
		logic        bad_trail;
	} glyph_word_t;

	typedef struct packed {
		logic       load;
		logic       place;
		logic [8:0] start_x;
		logic [9:0] start_y;
		logic [5:0] width;
		logic [5:0] height;
	} cursor_cmd_t;

endpackage

[hw/rtl/tgl_text_if.sv]
// ----------------------------------------------------------------------------
// tgl_text_if
// Valid/ready channel that carries one text word.
// ----------------------------------------------------------------------------
interface tgl_text_if;
	logic               valid;
	logic               ready;
	tgl_pkg::text_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/tgl_glyph_if.sv]
// ----------------------------------------------------------------------------
// tgl_glyph_if
// Valid/ready channel that carries one glyph draw word.
// ----------------------------------------------------------------------------
interface tgl_glyph_if;
	logic                valid;
	logic                ready;
	tgl_pkg::glyph_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/tgl_decode.sv]
// ----------------------------------------------------------------------------
// tgl_decode
// Byte decoder: holds the hanzi lead byte, picks the glyph kind and size and
// computes the bitmap offset in the font store.
// ----------------------------------------------------------------------------
module tgl_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  tgl_pkg::text_word_t  word,
	input  logic                 large_font,
	output logic                 emit,
	output tgl_pkg::glyph_kind_t glyph_kind,
	output logic [20:0]          glyph_offset,
	output logic                 bad_trail,
	output tgl_pkg::cursor_cmd_t cmd
);
	import tgl_pkg::*;

	logic        lead_pending_q;
	logic [7:0]  lead_code_q;
	logic        is_start;
	logic        is_lead;
	logic        is_hanzi;
	logic        trail_ok;
	logic [6:0]  lead_idx;
	logic [6:0]  trail_idx;
	logic [13:0] hz_index;
	logic [13:0] lead_row;

	assign is_start  = (word.op == OP_START);
	assign is_hanzi  = !is_start && lead_pending_q;
	assign is_lead   = !is_start && !lead_pending_q && (word.code_byte >= HZ_BASE);
	assign trail_ok  = (word.code_byte >= HZ_BASE);
	assign lead_idx  = 7'(lead_code_q - HZ_BASE);
	assign trail_idx = 7'(word.code_byte - HZ_BASE);
	assign lead_row  = {7'd0, lead_idx} * {7'd0, HZ_ROW};
	assign hz_index  = lead_row + {7'd0, trail_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			lead_code_q    <= 8'd0;
		end else if (fire) begin
			if (is_start || is_hanzi) begin
				lead_pending_q <= 1'b0;
			end else if (is_lead) begin
				lead_pending_q <= 1'b1;
				lead_code_q    <= word.code_byte;
			end
		end
	end

	always_comb begin
		emit         = !is_start && !is_lead;
		bad_trail    = 1'b0;
		glyph_offset = 21'd0;
		cmd.load     = is_start;
		cmd.place    = !is_start && !is_lead;
		cmd.start_x  = word.start_x;
		cmd.start_y  = word.start_y;
		if (is_hanzi) begin
			bad_trail    = !trail_ok;
			glyph_kind   = large_font ? KIND_HANZI_LARGE : KIND_HANZI_SMALL;
			cmd.width    = large_font ? 6'd32 : 6'd16;
			cmd.height   = large_font ? 6'd32 : 6'd16;
			if (trail_ok) begin
				glyph_offset = large_font ? {hz_index, 7'd0} : {2'd0, hz_index, 5'd0};
			end
		end else begin
			glyph_kind   = large_font ? KIND_ASCII_LARGE : KIND_ASCII_SMALL;
			cmd.width    = large_font ? 6'd16 : 6'd8;
			cmd.height   = large_font ? 6'd32 : 6'd16;
			glyph_offset = large_font ? {7'd0, word.code_byte, 6'd0}
				: {9'd0, word.code_byte, 4'd0};
		end
	end

endmodule

[hw/rtl/tgl_cursor.sv]
// ----------------------------------------------------------------------------
// tgl_cursor
// Cursor state: line wrap at the screen width, row advance with saturation,
// and column advance by the glyph width.
// ----------------------------------------------------------------------------
module tgl_cursor #(
	parameter int unsigned SCREEN_WIDTH = 480
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  tgl_pkg::cursor_cmd_t cmd,
	output logic [8:0]           pos_x,
	output logic [9:0]           pos_y
);
	import tgl_pkg::*;

	localparam logic [9:0] SCREEN_W = 10'(SCREEN_WIDTH);

	logic [8:0]  col_q;
	logic [9:0]  row_q;
	logic        wrap;
	logic [10:0] row_sum;
	logic [9:0]  row_wrapped;

	assign wrap        = ({1'b0, col_q} >= (SCREEN_W - {4'd0, cmd.width}));
	assign row_sum     = {1'b0, row_q} + {5'd0, cmd.height};
	assign row_wrapped = (row_sum > {1'b0, ROW_MAX}) ? ROW_MAX : row_sum[9:0];
	assign pos_x       = wrap ? 9'd0 : col_q;
	assign pos_y       = wrap ? row_wrapped : row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 9'd0;
			row_q <= 10'd0;
		end else if (fire) begin
			if (cmd.load) begin
				col_q <= cmd.start_x;
				row_q <= cmd.start_y;
			end else if (cmd.place) begin
				col_q <= pos_x + {3'd0, cmd.width};
				row_q <= pos_y;
			end
		end
	end

endmodule

[hw/rtl/text_glyph_layout.sv]
// ----------------------------------------------------------------------------
// text_glyph_layout
// Text layout engine for a character overlay.
//
// Text words enter on text_in. A word with op set to start loads the cursor
// and drops any held lead byte. A text byte above 160 is held as a hanzi
// lead; the next byte completes the pair. Every other byte, and every
// trail, yields one draw word on glyph_out with the glyph kind, the bitmap
// offset in its font store, the top-left position and the text color.
// The glyph set size and the color come from the write port (cfg_we,
// cfg_index, cfg_data); write them only while the block is idle.
// A word is registered at the input and its draw word is then registered
// at the output, where glyph_out.valid rises with it.
// One word is accepted every cycle while glyph_out does not stall; the cursor
// update for a word finishes in the cycle it leaves the input register.
// When glyph_out stalls, the input register holds one more word and then
// text_in.ready drops. Reset clears the cursor and lead byte, selects the
// large glyph set and sets the color to 0xC0C0C0.
// ----------------------------------------------------------------------------
module text_glyph_layout #(
	parameter int unsigned SCREEN_WIDTH = 480
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tgl_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tgl_pkg::CFG_DATA_W-1:0]      cfg_data,
	tgl_text_if.sink                            text_in,
	tgl_glyph_if.source                         glyph_out
);
	import tgl_pkg::*;

	logic        large_font_q;
	logic [23:0] text_color_q;
	logic        valid_s1;
	text_word_t  word_s1;
	logic        valid_s2;
	glyph_word_t word_s2;
	logic        advance;
	logic        emit;
	glyph_kind_t kind;
	logic [20:0] offset;
	logic        bad;
	cursor_cmd_t cmd;
	logic [8:0]  pos_x;
	logic [9:0]  pos_y;

	assign advance       = valid_s1 && (!valid_s2 || glyph_out.ready);
	assign text_in.ready = !valid_s1 || advance;
	assign glyph_out.valid = valid_s2;
	assign glyph_out.data  = word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			large_font_q <= LARGE_FONT_RESET;
			text_color_q <= TEXT_COLOR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LARGE_FONT: large_font_q <= cfg_data[0];
				REG_TEXT_COLOR: text_color_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			word_s1 <= text_in.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= emit;
		end else if (glyph_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			word_s2.glyph_kind   <= kind;
			word_s2.glyph_offset <= offset;
			word_s2.pos_x        <= pos_x;
			word_s2.pos_y        <= pos_y;
			word_s2.draw_color   <= text_color_q;
			word_s2.bad_trail    <= bad;
		end
	end

	tgl_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.word         (word_s1),
		.large_font   (large_font_q),
		.emit         (emit),
		.glyph_kind   (kind),
		.glyph_offset (offset),
		.bad_trail    (bad),
		.cmd          (cmd)
	);

	tgl_cursor #(
		.SCREEN_WIDTH (SCREEN_WIDTH)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.cmd    (cmd),
		.pos_x  (pos_x),
		.pos_y  (pos_y)
	);

endmodule
